FILE: design/midi_note_sticky_channel_router_top_assert.svh
// Assertion macros shared by the router modules.
`ifndef MIDI_NOTE_STICKY_CHANNEL_ROUTER_TOP_ASSERT_SVH
`define MIDI_NOTE_STICKY_CHANNEL_ROUTER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define MNSCR_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("router assertion failed");

// Same-cycle implication.
`define MNSCR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("router assertion failed");

// Next-cycle implication.
`define MNSCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("router assertion failed");

`endif

FILE: design/mnscr_pkg.sv
// Shared constants, codes and types of the MIDI sticky-channel router.
`timescale 1ns / 1ps

package mnscr_pkg;

  localparam int DEVICE_COUNT     = 4;
  localparam int OUTPUT_COUNT     = 16;
  localparam int PORT_W           = $clog2(OUTPUT_COUNT);
  localparam int NOTES_PER_DEVICE = 128;
  localparam int NOTE_MEM_DEPTH   = DEVICE_COUNT * NOTES_PER_DEVICE;
  localparam int NOTE_ADDR_W      = $clog2(NOTE_MEM_DEPTH);
  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

  // High nibbles of the status byte that matter to routing.
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

  localparam logic [63:0] EXTERNAL_MAP_RESET  = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] SYNTH_MASK_A_RESET  = 64'h0008_0004_0002_0001;
  localparam logic [63:0] SYNTH_MASK_B_RESET  = 64'h0080_0040_0020_0010;
  localparam logic [63:0] SYNTH_MASK_C_RESET  = 64'h0800_0400_0200_0100;
  localparam logic [63:0] SYNTH_MASK_D_RESET  = 64'h8000_4000_2000_1000;
  localparam logic [3:0]  DEVICE_ENABLE_RESET = 4'hF;

  typedef enum logic [2:0] {
    REG_CURRENT_CHANNEL,
    REG_DESTINATION_MAP,
    REG_EXTERNAL_MAP,
    REG_SYNTH_MASK_A,
    REG_SYNTH_MASK_B,
    REG_SYNTH_MASK_C,
    REG_SYNTH_MASK_D,
    REG_DEVICE_ENABLE
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_SYNTH,
    MODE_SAMPLER,
    MODE_EXTERNAL,
    MODE_NONE
  } mode_t;

  typedef struct packed {
    logic [PORT_W-1:0] current_channel;
    logic [31:0]       destination_map;
    logic [63:0]       external_map;
    logic [3:0][63:0]  synth_mask;
    logic [3:0]        device_enable;
  } cfg_t;

  // A routed message waiting to be expanded into results.
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [7:0]        status;
    logic [7:0]        data_one;
    logic [7:0]        data_two;
    logic [1:0]        byte_count;
    logic [11:0]       frame_offset;
  } job_t;

endpackage

FILE: design/mnscr_if.sv
// Valid/ready channel interfaces for incoming messages and routed results.
`timescale 1ns / 1ps

interface mnscr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  device;
  logic [7:0]  status;
  logic [7:0]  data_one;
  logic [7:0]  data_two;
  logic [1:0]  byte_count;
  logic [11:0] frame_offset;

  modport source (output valid, device, status, data_one, data_two, byte_count,
                  frame_offset, input ready);
  modport sink (input valid, device, status, data_one, data_two, byte_count,
                frame_offset, output ready);
endinterface

interface mnscr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_port;
  logic [7:0]  out_status;
  logic [7:0]  out_data_one;
  logic [7:0]  out_data_two;
  logic [1:0]  out_byte_count;
  logic [11:0] out_frame_offset;
  logic        last;

  modport source (output valid, out_port, out_status, out_data_one, out_data_two,
                  out_byte_count, out_frame_offset, last, input ready);
  modport sink (input valid, out_port, out_status, out_data_one, out_data_two,
                out_byte_count, out_frame_offset, last, output ready);
endinterface

FILE: design/mnscr_front.sv
// Front end: accepts messages, filters them and resolves the sticky note output.
`timescale 1ns / 1ps
`include "midi_note_sticky_channel_router_top_assert.svh"

module mnscr_front (
  input  logic              clk,
  input  logic              rst,
  input  mnscr_pkg::cfg_t   cfg,
  mnscr_in_if.sink          midi_in,
  output logic              job_valid,
  input  logic              job_ready,
  output mnscr_pkg::job_t   job
);
  import mnscr_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_PUSH} state_t;

  typedef struct packed {
    logic              held;
    logic [PORT_W-1:0] port;
  } note_entry_t;

  state_t                 state;
  logic [NOTE_ADDR_W-1:0] clear_addr;
  logic [NOTE_ADDR_W-1:0] item_addr;
  logic                   is_on;
  logic                   note_job;

  note_entry_t            note_mem [NOTE_MEM_DEPTH];
  note_entry_t            rd_entry;
  note_entry_t            wr_entry;
  logic                   wr_en;
  logic [NOTE_ADDR_W-1:0] wr_addr;
  logic [NOTE_ADDR_W-1:0] in_addr;

  logic                   in_accept;
  logic                   dev_on;
  logic                   is_system;
  logic                   is_note;
  logic [PORT_W-1:0]      resolved_port;

  assign midi_in.ready = (state == S_IDLE);
  assign in_accept     = midi_in.valid && midi_in.ready;
  assign job_valid     = (state == S_PUSH);

  // Only the low seven bits of the note number select the note state.
  assign in_addr   = NOTE_ADDR_W'({midi_in.device, midi_in.data_one[6:0]});
  assign dev_on    = (32'(midi_in.device) < DEVICE_COUNT) &&
                     cfg.device_enable[midi_in.device];
  assign is_system = (midi_in.status[7:4] == HI_SYSTEM);
  assign is_note   = (midi_in.status[7:4] == HI_NOTE_OFF) ||
                     (midi_in.status[7:4] == HI_NOTE_ON);

  // A note-on for a note that is not held takes the current channel captured at
  // acceptance; everything else keeps the recorded output.
  assign resolved_port = (is_on && !rd_entry.held) ? job.port : rd_entry.port;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = item_addr;
    wr_entry = '{held: is_on, port: resolved_port};
    if (state == S_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = clear_addr;
      wr_entry = '0;
    end else if (state == S_READ) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      note_mem[wr_addr] <= wr_entry;
    end
    rd_entry <= note_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == NOTE_ADDR_W'(NOTE_MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            job.port         <= cfg.current_channel;
            job.status       <= midi_in.status;
            job.data_one     <= midi_in.data_one;
            job.data_two     <= midi_in.data_two;
            job.byte_count   <= midi_in.byte_count;
            job.frame_offset <= midi_in.frame_offset;
            item_addr        <= in_addr;
            is_on            <= (midi_in.status[7:4] == HI_NOTE_ON);
            note_job         <= is_note;
            if (dev_on && !is_system) begin
              state <= is_note ? S_READ : S_PUSH;
            end
          end
        end
        S_READ: begin
          job.port        <= resolved_port;
          job.status[3:0] <= resolved_port;
          state           <= S_PUSH;
        end
        S_PUSH: begin
          if (job_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MNSCR_ASSERT_IMPLY(a_note_status_port, job_valid && note_job, job.status[3:0] == job.port)

endmodule

FILE: design/mnscr_queue.sv
// Short FIFO of routed messages between the front and back ends.
`timescale 1ns / 1ps
`include "midi_note_sticky_channel_router_top_assert.svh"

module mnscr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  mnscr_pkg::job_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mnscr_pkg::job_t pop_data
);
  import mnscr_pkg::*;

  job_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   push_fire;
  logic                   pop_fire;

  assign push_ready = (count != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  `MNSCR_ASSERT(a_count_bound, count <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
  `MNSCR_ASSERT(a_ptr_count, QUEUE_PTR_W'(wr_ptr - rd_ptr) == count[QUEUE_PTR_W-1:0])

endmodule

FILE: design/mnscr_back.sv
// Back end: expands each routed message into results by destination mode.
`timescale 1ns / 1ps
`include "midi_note_sticky_channel_router_top_assert.svh"

module mnscr_back (
  input  logic            clk,
  input  logic            rst,
  input  mnscr_pkg::cfg_t cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  mnscr_pkg::job_t job,
  mnscr_out_if.source     route_out
);
  import mnscr_pkg::*;

  function automatic logic [3:0] lowest_set(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  job_t        cur;
  logic        active;
  logic [15:0] rem;
  logic        repl;

  logic        pop_fire;
  logic        slot_free;
  logic        emit;
  logic [15:0] rem_next;
  logic [3:0]  ch;
  mode_t       mode;
  logic [15:0] synth_mask;
  logic [3:0]  ext_ch;

  assign pop_ready = !active;
  assign pop_fire  = pop_valid && pop_ready;
  assign slot_free = !route_out.valid || route_out.ready;
  assign emit      = active && (rem != '0) && slot_free;
  assign rem_next  = rem & (rem - 1'b1);
  assign ch        = lowest_set(rem);

  assign mode       = mode_t'(cfg.destination_map[{job.port, 1'b0} +: 2]);
  assign synth_mask = cfg.synth_mask[job.port[3:2]][{job.port[1:0], 4'b0000} +: 16];
  assign ext_ch     = cfg.external_map[{job.port, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      route_out.valid <= 1'b0;
    end else begin
      if (pop_fire) begin
        cur    <= job;
        active <= 1'b1;
        // Sampler and external modes become a one-channel mask so a single
        // emit path serves every mode.
        unique case (mode)
          MODE_SYNTH: begin
            rem  <= synth_mask;
            repl <= 1'b1;
          end
          MODE_SAMPLER: begin
            rem  <= 16'h0001;
            repl <= 1'b0;
          end
          MODE_EXTERNAL: begin
            rem  <= 16'h0001 << ext_ch;
            repl <= 1'b1;
          end
          MODE_NONE: begin
            rem  <= '0;
            repl <= 1'b0;
          end
          default: rem <= '0;
        endcase
      end else if (emit) begin
        rem <= rem_next;
        if (rem_next == '0) begin
          active <= 1'b0;
        end
      end else if (active && (rem == '0)) begin
        active <= 1'b0;
      end

      if (emit) begin
        route_out.valid            <= 1'b1;
        route_out.out_port         <= cur.port;
        route_out.out_status       <= repl ? {cur.status[7:4], ch} : cur.status;
        route_out.out_data_one     <= cur.data_one;
        route_out.out_data_two     <= cur.data_two;
        route_out.out_byte_count   <= cur.byte_count;
        route_out.out_frame_offset <= cur.frame_offset;
        route_out.last             <= (rem_next == '0);
      end else if (route_out.ready) begin
        route_out.valid <= 1'b0;
      end
    end
  end

  `MNSCR_ASSERT_NEXT(a_last_ends_job, emit && (rem_next == '0), !active)
  `MNSCR_ASSERT_IMPLY(a_pending_keeps_job, route_out.valid && !route_out.last, active)

endmodule

FILE: design/midi_note_sticky_channel_router_top.sv
// MIDI sticky-channel router top level: configuration registers, front, queue, back.
// Path: a note message passes the front's read state before its push state, any other goes
// straight to the push state; the queue holds it and the back end registers its results,
// one result per cycle while the result side is ready (up to 16 for an item, possibly none).
// The front takes a new item only after pushing the last; the back, one item at a time.
// Reset: synchronous; a clearing pass then sweeps all 512 entries of the note memory.
`timescale 1ns / 1ps

module midi_note_sticky_channel_router_top (
  input  logic                  clk,
  input  logic                  rst,
  mnscr_in_if.sink              midi_in,
  mnscr_out_if.source           route_out,
  input  logic                  write_enable,
  input  mnscr_pkg::reg_index_t write_index,
  input  logic [63:0]           write_data
);
  import mnscr_pkg::*;

  cfg_t cfg;
  logic front_valid;
  logic front_ready;
  job_t front_job;
  logic back_valid;
  logic back_ready;
  job_t back_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_channel <= '0;
      cfg.destination_map <= '0;
      cfg.external_map    <= EXTERNAL_MAP_RESET;
      cfg.synth_mask[0]   <= SYNTH_MASK_A_RESET;
      cfg.synth_mask[1]   <= SYNTH_MASK_B_RESET;
      cfg.synth_mask[2]   <= SYNTH_MASK_C_RESET;
      cfg.synth_mask[3]   <= SYNTH_MASK_D_RESET;
      cfg.device_enable   <= DEVICE_ENABLE_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_CURRENT_CHANNEL: cfg.current_channel <= write_data[PORT_W-1:0];
        REG_DESTINATION_MAP: cfg.destination_map <= write_data[31:0];
        REG_EXTERNAL_MAP:    cfg.external_map    <= write_data;
        REG_SYNTH_MASK_A:    cfg.synth_mask[0]   <= write_data;
        REG_SYNTH_MASK_B:    cfg.synth_mask[1]   <= write_data;
        REG_SYNTH_MASK_C:    cfg.synth_mask[2]   <= write_data;
        REG_SYNTH_MASK_D:    cfg.synth_mask[3]   <= write_data;
        REG_DEVICE_ENABLE:   cfg.device_enable   <= write_data[3:0];
        default: ;
      endcase
    end
  end

  mnscr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .midi_in   (midi_in),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  mnscr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_job)
  );

  mnscr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (back_valid),
    .pop_ready (back_ready),
    .job       (back_job),
    .route_out (route_out)
  );

endmodule

FILE: tb/sv/mnscr_route_check.sv
// Watches both router channels, predicts the routed results and compares them.
`timescale 1ns / 1ps

module mnscr_route_check (
  input  logic                  clk,
  input  logic                  rst,
  mnscr_in_if                   midi_in,
  mnscr_out_if                  route_out,
  input  logic                  write_enable,
  input  mnscr_pkg::reg_index_t write_index,
  input  logic [63:0]           write_data,
  output int                    failures,
  output int                    pending,
  output int                    results_checked
);
  import mnscr_pkg::*;

  typedef struct packed {
    logic [3:0]  port;
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [1:0]  byte_count;
    logic [11:0] frame_offset;
    logic        last;
  } routed_t;

  logic [3:0]  cur_chan;
  logic [31:0] dest_map;
  logic [63:0] ext_map;
  logic [63:0] synth_masks [4];
  logic [3:0]  dev_en;

  bit         note_held [NOTE_MEM_DEPTH];
  logic [3:0] note_port [NOTE_MEM_DEPTH];

  routed_t routed_q [$];
  routed_t want;

  function automatic routed_t copy_of(logic [3:0] port, logic [7:0] status, logic last);
    routed_t r;
    r.port         = port;
    r.status       = status;
    r.data_one     = midi_in.data_one;
    r.data_two     = midi_in.data_two;
    r.byte_count   = midi_in.byte_count;
    r.frame_offset = midi_in.frame_offset;
    r.last         = last;
    return r;
  endfunction

  function automatic void route_message();
    logic [3:0]  port;
    logic [7:0]  status;
    logic [15:0] mask;
    int          slot;
    int          left;
    mode_t       mode;
    port   = cur_chan;
    status = midi_in.status;
    if (!dev_en[midi_in.device] || status[7:4] == HI_SYSTEM) return;
    if (status[7:4] == HI_NOTE_ON || status[7:4] == HI_NOTE_OFF) begin
      // Only the low seven bits of the note number select the note state.
      slot = int'(midi_in.device) * NOTES_PER_DEVICE + int'(midi_in.data_one[6:0]);
      if (status[7:4] == HI_NOTE_ON) begin
        // A note-on for a note already held keeps the output it was given first.
        if (!note_held[slot]) begin
          note_held[slot] = 1'b1;
          note_port[slot] = port;
        end
      end else begin
        note_held[slot] = 1'b0;
      end
      port        = note_port[slot];
      status[3:0] = port;
    end
    mode = mode_t'(dest_map[2*port +: 2]);
    case (mode)
      MODE_SYNTH: begin
        mask = synth_masks[port[3:2]][16*port[1:0] +: 16];
        left = $countones(mask);
        for (int ch = 0; ch < 16; ch++) begin
          if (mask[ch]) begin
            left--;
            routed_q.push_back(copy_of(port, {status[7:4], 4'(ch)}, left == 0));
          end
        end
      end
      MODE_SAMPLER: routed_q.push_back(copy_of(port, status, 1'b1));
      MODE_EXTERNAL: routed_q.push_back(copy_of(port, {status[7:4], ext_map[4*port +: 4]}, 1'b1));
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [11:0] expected,
                             input logic [11:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0h, actual %0h", name, expected, actual);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_chan        = '0;
      dest_map        = '0;
      ext_map         = EXTERNAL_MAP_RESET;
      synth_masks[0]  = SYNTH_MASK_A_RESET;
      synth_masks[1]  = SYNTH_MASK_B_RESET;
      synth_masks[2]  = SYNTH_MASK_C_RESET;
      synth_masks[3]  = SYNTH_MASK_D_RESET;
      dev_en          = DEVICE_ENABLE_RESET;
      failures        = 0;
      results_checked = 0;
      routed_q.delete();
      for (int i = 0; i < NOTE_MEM_DEPTH; i++) begin
        note_held[i] = 1'b0;
        note_port[i] = '0;
      end
    end else begin
      if (route_out.valid && route_out.ready) begin
        if (routed_q.size() == 0) begin
          $error("unexpected result: port %0h status %0h", route_out.out_port,
                 route_out.out_status);
          failures++;
        end else begin
          want = routed_q.pop_front();
          check_field("out_port", 12'(want.port), 12'(route_out.out_port));
          check_field("out_status", 12'(want.status), 12'(route_out.out_status));
          check_field("out_data_one", 12'(want.data_one), 12'(route_out.out_data_one));
          check_field("out_data_two", 12'(want.data_two), 12'(route_out.out_data_two));
          check_field("out_byte_count", 12'(want.byte_count),
                      12'(route_out.out_byte_count));
          check_field("out_frame_offset", want.frame_offset, route_out.out_frame_offset);
          check_field("last", 12'(want.last), 12'(route_out.last));
          results_checked++;
        end
      end
      if (write_enable) begin
        case (write_index)
          REG_CURRENT_CHANNEL: cur_chan       = write_data[3:0];
          REG_DESTINATION_MAP: dest_map       = write_data[31:0];
          REG_EXTERNAL_MAP:    ext_map        = write_data;
          REG_SYNTH_MASK_A:    synth_masks[0] = write_data;
          REG_SYNTH_MASK_B:    synth_masks[1] = write_data;
          REG_SYNTH_MASK_C:    synth_masks[2] = write_data;
          REG_SYNTH_MASK_D:    synth_masks[3] = write_data;
          REG_DEVICE_ENABLE:   dev_en         = write_data[3:0];
          default: ;
        endcase
      end
      if (midi_in.valid && midi_in.ready) route_message();
    end
    pending <= routed_q.size();
  end

endmodule

FILE: tb/sv/midi_note_sticky_channel_router_top_tb.sv
// Stimulus, register settings and verdict for the MIDI sticky-channel router.
`timescale 1ns / 1ps

module midi_note_sticky_channel_router_top_tb;
  import mnscr_pkg::*;

  localparam int LIMIT             = 200000;
  localparam int HOLD_CYCLES       = 300;
  localparam int SETTLE_CYCLES     = 40;
  localparam int SEGMENTS          = 9;
  localparam int ITEMS_PER_SEGMENT = 11;

  localparam logic [3:0] HI_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] HI_CONTROL       = 4'hB;
  localparam logic [3:0] HI_PITCH_BEND    = 4'hE;

  typedef struct packed {
    logic [1:0]  device;
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [1:0]  byte_count;
    logic [11:0] frame_offset;
  } midi_msg_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        write_enable = 1'b0;
  reg_index_t  write_index  = REG_CURRENT_CHANNEL;
  logic [63:0] write_data   = '0;
  logic        hold_toggle  = 1'b0;

  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  int          failures;
  int          pending;
  int          results_checked;
  int unsigned cycle_count  = 0;
  int          sent_total     = 0;
  int          routed_total   = 0;
  int          settings_total = 0;
  cfg_t        live_cfg;

  mnscr_in_if  midi_in ();
  mnscr_out_if route_out ();

  midi_note_sticky_channel_router_top dut (
    .clk,
    .rst,
    .midi_in      (midi_in),
    .route_out    (route_out),
    .write_enable,
    .write_index,
    .write_data
  );

  mnscr_route_check route_check (
    .clk,
    .rst,
    .midi_in         (midi_in),
    .route_out       (route_out),
    .write_enable,
    .write_index,
    .write_data,
    .failures,
    .pending,
    .results_checked
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever hold_toggle flips.
  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left       = 0;
    hold_seen       = 1'b0;
    route_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        route_out.ready <= 1'b0;
      end else begin
        route_out.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic midi_msg_t msg(logic [1:0] device, logic [7:0] status,
                                    logic [7:0] data_one, logic [7:0] data_two,
                                    logic [1:0] byte_count, logic [11:0] frame_offset);
    midi_msg_t m;
    m.device       = device;
    m.status       = status;
    m.data_one     = data_one;
    m.data_two     = data_two;
    m.byte_count   = byte_count;
    m.frame_offset = frame_offset;
    return m;
  endfunction

  // Mostly note-on/note-off traffic over a small pool of notes, so that held notes
  // meet their note-offs, with other channel messages and system noise mixed in.
  function automatic midi_msg_t random_msg();
    midi_msg_t  m;
    int         pick;
    logic [6:0] note;
    pick           = $urandom_range(99);
    note           = ($urandom_range(99) < 80) ? 7'($urandom_range(0, 7))
                                                : 7'($urandom_range(0, 127));
    m.device       = 2'($urandom_range(0, 3));
    m.data_one     = {($urandom_range(9) == 0), note};
    m.data_two     = 8'($urandom);
    m.byte_count   = 2'($urandom_range(1, 3));
    m.frame_offset = 12'($urandom);
    if (pick < 40) begin
      m.status = {HI_NOTE_ON, 4'($urandom)};
    end else if (pick < 70) begin
      m.status = {HI_NOTE_OFF, 4'($urandom)};
    end else if (pick < 85) begin
      m.status = 8'($urandom_range({HI_POLY_PRESSURE, 4'h0}, {HI_PITCH_BEND, 4'hF}));
    end else if (pick < 92) begin
      m.status = 8'($urandom_range(0, 8'h7F));
    end else begin
      m.status = {HI_SYSTEM, 4'($urandom)};
    end
    return m;
  endfunction

  task automatic send_msg(input midi_msg_t m);
    if ($urandom_range(99) < in_idle_pct) begin
      midi_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    midi_in.valid        <= 1'b1;
    midi_in.device       <= m.device;
    midi_in.status       <= m.status;
    midi_in.data_one     <= m.data_one;
    midi_in.data_two     <= m.data_two;
    midi_in.byte_count   <= m.byte_count;
    midi_in.frame_offset <= m.frame_offset;
    @(posedge clk);
    while (!midi_in.ready) @(posedge clk);
    sent_total++;
    if (live_cfg.device_enable[m.device] && m.status[7:4] != HI_SYSTEM) routed_total++;
  endtask

  task automatic configure(input cfg_t c);
    reg_index_t idx;
    idx = idx.first();
    write_enable <= 1'b1;
    repeat (idx.num()) begin
      write_index <= idx;
      case (idx)
        REG_CURRENT_CHANNEL: write_data <= 64'(c.current_channel);
        REG_DESTINATION_MAP: write_data <= 64'(c.destination_map);
        REG_EXTERNAL_MAP:    write_data <= c.external_map;
        REG_SYNTH_MASK_A:    write_data <= c.synth_mask[0];
        REG_SYNTH_MASK_B:    write_data <= c.synth_mask[1];
        REG_SYNTH_MASK_C:    write_data <= c.synth_mask[2];
        REG_SYNTH_MASK_D:    write_data <= c.synth_mask[3];
        REG_DEVICE_ENABLE:   write_data <= 64'(c.device_enable);
        default: ;
      endcase
      @(posedge clk);
      idx = idx.next();
    end
    write_enable <= 1'b0;
    live_cfg = c;
    settings_total++;
  endtask

  // Stop offering items, wait for every predicted result, then let dropped items drain.
  task automatic settle();
    midi_in.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    cfg_t c;
    int   target;
    int   send_cap;
    midi_in.valid        = 1'b0;
    midi_in.device       = '0;
    midi_in.status       = '0;
    midi_in.data_one     = '0;
    midi_in.data_two     = '0;
    midi_in.byte_count   = 2'd1;
    midi_in.frame_offset = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    in_idle_pct  = 18;
    out_idle_pct = 85;

    // Directed setting: output 1 sampler, 2 external, 3 silent, 4 synth on every
    // channel, 5 synth with an empty mask, 15 external on channel zero.
    c.current_channel             = 4'd1;
    c.destination_map             = '0;
    c.destination_map[2*1 +: 2]   = MODE_SAMPLER;
    c.destination_map[2*2 +: 2]   = MODE_EXTERNAL;
    c.destination_map[2*3 +: 2]   = MODE_NONE;
    c.destination_map[2*15 +: 2]  = MODE_EXTERNAL;
    c.external_map                = EXTERNAL_MAP_RESET;
    c.external_map[4*2 +: 4]      = 4'hC;
    c.external_map[4*15 +: 4]     = 4'h0;
    c.synth_mask[0]               = SYNTH_MASK_A_RESET;
    c.synth_mask[1]               = SYNTH_MASK_B_RESET;
    c.synth_mask[2]               = SYNTH_MASK_C_RESET;
    c.synth_mask[3]               = SYNTH_MASK_D_RESET;
    c.synth_mask[1][15:0]         = 16'hFFFF;
    c.synth_mask[1][31:16]        = 16'h0000;
    c.device_enable               = 4'b1011;
    configure(c);
    send_msg(msg(2'd0, {HI_NOTE_ON, 4'h7}, 8'd60, 8'd100, 2'd3, 12'd17));
    send_msg(msg(2'd0, {HI_NOTE_ON, 4'h0}, 8'd60, 8'd90, 2'd3, 12'd18));
    send_msg(msg(2'd1, {HI_CONTROL, 4'h3}, 8'd7, 8'd64, 2'd3, 12'd100));
    send_msg(msg(2'd3, 8'h00, 8'h00, 8'h00, 2'd1, 12'd0));
    send_msg(msg(2'd3, 8'h7F, 8'hFF, 8'hFF, 2'd3, 12'hFFF));
    send_msg(msg(2'd0, {HI_SYSTEM, 4'h0}, 8'd1, 8'd2, 2'd3, 12'd5));
    send_msg(msg(2'd1, {HI_SYSTEM, 4'hF}, 8'd1, 8'd2, 2'd1, 12'd6));
    send_msg(msg(2'd2, {HI_NOTE_ON, 4'h1}, 8'd40, 8'd50, 2'd3, 12'd7));
    send_msg(msg(2'd1, {HI_NOTE_OFF, 4'h5}, 8'd10, 8'd0, 2'd3, 12'd8));
    send_msg(msg(2'd3, {HI_NOTE_ON, 4'hF}, 8'hFF, 8'hFF, 2'd3, 12'hFFF));
    send_msg(msg(2'd0, {HI_NOTE_ON, 4'h2}, 8'h80, 8'h00, 2'd1, 12'd0));
    send_msg(msg(2'd0, {HI_POLY_PRESSURE, 4'h0}, 8'd60, 8'd33, 2'd3, 12'd9));
    send_msg(msg(2'd1, {HI_NOTE_ON, 4'hF}, 8'd20, 8'd1, 2'd2, 12'd10));
    send_msg(msg(2'd3, {HI_PITCH_BEND, 4'hF}, 8'h00, 8'h40, 2'd3, 12'd11));
    settle();

    // Notes started on output 1 must stay there after the current channel moves.
    c.current_channel = 4'd4;
    configure(c);
    send_msg(msg(2'd0, {HI_NOTE_OFF, 4'h0}, 8'd60, 8'd0, 2'd3, 12'd20));
    send_msg(msg(2'd0, {HI_NOTE_ON, 4'h0}, 8'd61, 8'd70, 2'd3, 12'd21));
    send_msg(msg(2'd0, {HI_CONTROL, 4'h9}, 8'd1, 8'd127, 2'd3, 12'd22));
    send_msg(msg(2'd3, {HI_NOTE_OFF, 4'hF}, 8'hFF, 8'd0, 2'd2, 12'd23));
    settle();

    c.current_channel = 4'd2;
    configure(c);
    send_msg(msg(2'd1, {HI_CONTROL, 4'h1}, 8'd10, 8'd20, 2'd3, 12'd30));
    send_msg(msg(2'd1, {HI_NOTE_ON, 4'h0}, 8'd30, 8'd80, 2'd3, 12'd31));
    settle();

    c.current_channel = 4'd3;
    configure(c);
    send_msg(msg(2'd0, {HI_CONTROL, 4'h0}, 8'd11, 8'd12, 2'd3, 12'd40));
    send_msg(msg(2'd1, {HI_NOTE_OFF, 4'h0}, 8'd30, 8'd0, 2'd3, 12'd41));
    settle();

    c.current_channel = 4'd5;
    configure(c);
    send_msg(msg(2'd0, {HI_NOTE_ON, 4'h0}, 8'd70, 8'd60, 2'd3, 12'd50));
    send_msg(msg(2'd1, {HI_PITCH_BEND, 4'h0}, 8'd0, 8'd64, 2'd3, 12'd51));
    settle();

    c.current_channel = 4'd15;
    configure(c);
    send_msg(msg(2'd3, {HI_CONTROL, 4'h6}, 8'd64, 8'd0, 2'd3, 12'd60));
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      in_idle_pct  = (seg < 3) ? 18 : (seg < 6) ? 85 : 0;
      out_idle_pct = (seg < 3) ? 85 : (seg < 6) ? 18 : 0;
      if (seg == 0) begin
        // Every output synth on all sixteen channels: the most results per item.
        c.current_channel = 4'($urandom);
        c.destination_map = '0;
        c.external_map    = '0;
        c.synth_mask      = '1;
        c.device_enable   = 4'hF;
      end else if (seg == 1) begin
        c.current_channel = 4'hF;
        c.destination_map = '1;
        c.external_map    = '1;
        c.synth_mask      = '0;
        c.device_enable   = 4'h0;
      end else begin
        c.current_channel = 4'($urandom);
        c.destination_map = $urandom;
        c.external_map    = {$urandom, $urandom};
        for (int k = 0; k < 4; k++) begin
          c.synth_mask[k] = $urandom_range(0, 1) ? ({$urandom, $urandom} & {$urandom, $urandom})
                                                 : {$urandom, $urandom};
        end
        c.device_enable   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF;
      end
      configure(c);
      // Segment 0 holds the result side off at length as items come, so the block backs up.
      if (seg == 0) hold_toggle <= ~hold_toggle;
      target   = routed_total + ITEMS_PER_SEGMENT;
      send_cap = sent_total + 3 * ITEMS_PER_SEGMENT;
      while (routed_total < target && sent_total < send_cap) send_msg(random_msg());
      settle();
    end

    @(negedge clk);
    $display("Offered %0d messages, %0d of them routable, across %0d register settings.",
             sent_total, routed_total, settings_total);
    $display("Compared %0d routed results, including a long result-side hold-off.",
             results_checked);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
